@@ design/mccls_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI CC learn and scale: shared package
// Constants, control/status bundles, the exp2 factor table and helpers.
// ----------------------------------------------------------------------------
package mccls_pkg;

   localparam int FRAC_BITS = 16;
   localparam int LQ        = 30;
   localparam int NORM_W    = 34;
   localparam int DIV_W     = 48;
   localparam int DIV_SHIFT = 7;
   // A dividend below 2^44 folds down to a residue of at most 127 in seven
   // steps; one more step leaves margin.
   localparam int DIV_STEPS = 8;
   localparam int LOG_STEPS = LQ;
   localparam int CNT_W     = 6;

   localparam logic [NORM_W-1:0] ONE_Q     = NORM_W'(1) << FRAC_BITS;
   localparam logic [7:0]        DIVISOR   = 8'd127;
   localparam logic [DIV_W-1:0]  ROUND_ADD = DIV_W'(63);
   localparam logic [3:0]        CC_STATUS = 4'hB;
   localparam logic              OP_LEARN  = 1'b1;

   localparam logic [1:0] CSR_RANGE_MIN = 2'd0;
   localparam logic [1:0] CSR_RANGE_MAX = 2'd1;
   localparam logic [1:0] CSR_LOG_MODE  = 2'd2;

   typedef enum logic [1:0] {
      KIND_DONE,
      KIND_LIN,
      KIND_LOG
   } kind_type;

   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       norm;
      logic       sqr;
      logic       load_b;
      logic       mul;
      logic       mul_log;
      logic       div_load;
      logic       div_step;
      logic       exp_load;
      logic       exp_step;
      logic [4:0] exp_idx;
      logic       shift;
      logic       fin_log;
      logic       fin_lin;
      logic       publish;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     norm_done;
   } dp_sts_type;

   typedef logic [31:0] exp_tbl_type [LOG_STEPS];

   function automatic logic [63:0] isqrt64(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x    = x_arg;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Factors 2^(2^-(k+1)) in Q.30, each a floor square root of the previous one.
   function automatic exp_tbl_type build_exp_tbl();
      exp_tbl_type tbl;
      logic [63:0] c;
      c = isqrt64(64'd1 << (2 * LQ + 1));
      for (int k = 0; k < LOG_STEPS; k++) begin
         tbl[k] = c[31:0];
         c = isqrt64(c << LQ);
      end
      return tbl;
   endfunction

   localparam exp_tbl_type EXP_TBL = build_exp_tbl();

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x[65:31] == '0 || x[65:31] == '1) begin
         return x[31:0];
      end else if (x[65]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

endpackage

@@ design/mccls_req_if.sv @@
// ----------------------------------------------------------------------------
// MIDI CC learn and scale: request channel
// Valid/ready channel carrying one MIDI event or a learn-arm command.
// ----------------------------------------------------------------------------
interface mccls_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic        is_complete_midi;
   logic [7:0]  status_byte;
   logic [7:0]  controller_number;
   logic [7:0]  controller_value;
   logic [15:0] frame_offset;

   modport source (
      output valid, op, is_complete_midi, status_byte, controller_number,
             controller_value, frame_offset,
      input  ready
   );
   modport sink (
      input  valid, op, is_complete_midi, status_byte, controller_number,
             controller_value, frame_offset,
      output ready
   );
endinterface

@@ design/mccls_rsp_if.sv @@
// ----------------------------------------------------------------------------
// MIDI CC learn and scale: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface mccls_rsp_if;
   logic               valid;
   logic               ready;
   logic               forwarded;
   logic               value_valid;
   logic signed [31:0] mapped_value;
   logic               range_error;
   logic [15:0]        out_frame_offset;

   modport source (
      output valid, forwarded, value_valid, mapped_value, range_error,
             out_frame_offset,
      input  ready
   );
   modport sink (
      input  valid, forwarded, value_valid, mapped_value, range_error,
             out_frame_offset,
      output ready
   );
endinterface

@@ design/mccls_ctrl.sv @@
// ----------------------------------------------------------------------------
// MIDI CC learn and scale: controller
// Sequences decode, log2, divide, exp2 and result hand-off in the datapath.
// ----------------------------------------------------------------------------
module mccls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output mccls_pkg::dp_cmd_type cmd,
   input  mccls_pkg::dp_sts_type sts
);
   import mccls_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_NORM_A, S_SQR_A, S_LOAD_B, S_NORM_B, S_SQR_B,
      S_MUL, S_DLOAD, S_DIV, S_EXP_LOAD, S_EXP, S_SHIFT, S_FIN_LOG,
      S_FIN_LIN, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             log_path_ff, log_path_in;
   logic             out_valid_ff, out_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      log_path_in  = log_path_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            case (sts.kind)
               KIND_LIN: begin
                  log_path_in = 1'b0;
                  state_in    = S_MUL;
               end
               KIND_LOG: begin
                  log_path_in = 1'b1;
                  state_in    = S_NORM_A;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_NORM_A, S_NORM_B: begin
            cmd.norm = 1'b1;
            if (sts.norm_done) begin
               cnt_in   = '0;
               state_in = (state_ff == S_NORM_A) ? S_SQR_A : S_SQR_B;
            end
         end
         S_SQR_A, S_SQR_B: begin
            cmd.sqr = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LOG_STEPS - 1)) begin
               state_in = (state_ff == S_SQR_A) ? S_LOAD_B : S_MUL;
            end
         end
         S_LOAD_B: begin
            cmd.load_b = 1'b1;
            state_in   = S_NORM_B;
         end
         S_MUL: begin
            cmd.mul     = 1'b1;
            cmd.mul_log = log_path_ff;
            state_in    = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = log_path_ff ? S_EXP_LOAD : S_FIN_LIN;
            end
         end
         S_EXP_LOAD: begin
            cmd.exp_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_EXP;
         end
         S_EXP: begin
            cmd.exp_step = 1'b1;
            cmd.exp_idx  = cnt_ff[4:0];
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LOG_STEPS - 1)) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = S_FIN_LOG;
         end
         S_FIN_LOG: begin
            cmd.fin_log = 1'b1;
            state_in    = S_DONE;
         end
         S_FIN_LIN: begin
            cmd.fin_lin = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // Hand the result over only once the output register is free.
            if (!out_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         log_path_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         log_path_ff  <= log_path_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted transaction did not enter decode");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!out_valid_ff || rsp_ready))
      else $error("result published over a pending transaction");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider step count overrun");

   a_exp_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXP || state_ff == S_SQR_A || state_ff == S_SQR_B)
      |-> (cnt_ff < CNT_W'(LOG_STEPS)))
      else $error("log/exp step count overrun");

endmodule

@@ design/mccls_dp.sv @@
// ----------------------------------------------------------------------------
// MIDI CC learn and scale: datapath
// Learn state, range registers, iterative log2, divide by 127, exp2, output.
// ----------------------------------------------------------------------------
module mccls_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  mccls_pkg::dp_cmd_type cmd,
   output mccls_pkg::dp_sts_type sts,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic                  in_op,
   input  logic                  in_complete,
   input  logic [7:0]            in_status,
   input  logic [7:0]            in_number,
   input  logic [7:0]            in_value,
   input  logic [15:0]           in_frame,
   output logic                  out_forwarded,
   output logic                  out_value_valid,
   output logic signed [31:0]    out_scaled,
   output logic                  out_range_error,
   output logic [15:0]           out_frame
);
   import mccls_pkg::*;

   // Configuration and learn state.
   logic signed [31:0] mn_ff, mx_ff;
   logic               log_ff;
   logic [7:0]         sel_ff;
   logic               armed_ff;

   // Captured request.
   logic        op_ff, cmpl_ff;
   logic [7:0]  status_ff, number_ff, value_ff;
   logic [15:0] frame_ff;

   // Working registers.
   logic [32:0]        off_ff;
   logic [NORM_W-1:0]  x_ff;
   logic [5:0]         n_ff;
   logic [LQ:0]        m_ff;
   logic [LQ-1:0]      frac_ff;
   logic [35:0]        la_ff;
   logic signed [DIV_W-1:0] prod_ff;
   logic               neg_ff;
   logic [DIV_W-1:0]   dq_ff;
   logic [DIV_W-1:0]   rem_ff;
   logic signed [17:0] ip_ff;
   logic [31:0]        mant_ff;
   logic [63:0]        p_ff;

   // Result being built and the output register.
   logic               res_fwd_ff, res_vv_ff, res_err_ff;
   logic signed [31:0] res_val_ff;
   logic               o_fwd_ff, o_vv_ff, o_err_ff;
   logic signed [31:0] o_val_ff;
   logic [15:0]        o_frame_ff;

   logic                     is_cc, match;
   logic signed [32:0]       off_c;
   logic signed [NORM_W-1:0] a_c, b_c;
   logic                     b_nonpos;
   logic [61:0]              sq_prod;
   logic [31:0]              sq_top;
   logic signed [36:0]       diff_c;
   logic signed [DIV_W-1:0]  prod_c;
   logic [DIV_W-1:0]         mag_c;
   logic [DIV_W-1:0]         quo_c;
   logic signed [DIV_W-1:0]  q_c;
   logic signed [DIV_W-1:0]  t_c;
   logic [63:0]              exp_prod;
   logic [63:0]              exp_rnd;
   logic signed [18:0]       sh_c;
   logic [18:0]              sneg_c;
   logic [5:0]               s_c;
   logic [63:0]              p_c;
   logic signed [31:0]       val_log, val_lin;

   assign is_cc    = cmpl_ff && (status_ff[7:4] == CC_STATUS);
   assign match    = armed_ff | (number_ff == sel_ff);
   assign off_c    = mn_ff[31] ? -$signed({mn_ff[31], mn_ff}) : 33'sd0;
   assign a_c      = $signed({{2{mn_ff[31]}}, mn_ff}) + $signed(ONE_Q)
                     + $signed({off_c[32], off_c});
   assign b_c      = $signed({{2{mx_ff[31]}}, mx_ff}) + $signed(ONE_Q)
                     + $signed({off_c[32], off_c});
   assign b_nonpos = b_c[NORM_W-1] || (b_c == '0);

   always_comb begin
      if (op_ff == OP_LEARN || !is_cc || !match) begin
         sts.kind = KIND_DONE;
      end else if (log_ff) begin
         sts.kind = b_nonpos ? KIND_DONE : KIND_LOG;
      end else begin
         sts.kind = KIND_LIN;
      end
      sts.norm_done = x_ff[NORM_W-1];
   end

   // Squaring step of the log2 mantissa.
   assign sq_prod = m_ff * m_ff;
   assign sq_top  = sq_prod[61:30];

   // Numerator of the interpolation, then magnitude plus half divisor.
   assign diff_c = cmd.mul_log
                   ? ($signed({1'b0, n_ff, frac_ff}) - $signed({1'b0, la_ff}))
                   : ($signed({{5{mx_ff[31]}}, mx_ff}) - $signed({{5{mn_ff[31]}}, mn_ff}));
   assign prod_c = $signed({{11{diff_c[36]}}, diff_c}) * $signed({40'b0, value_ff});
   assign mag_c  = (prod_ff[DIV_W-1] ? DIV_W'(-prod_ff) : DIV_W'(prod_ff)) + ROUND_ADD;

   // Divide by 127 by folding: since 128 = 127 + 1, each step moves the bits
   // above the low seven into the quotient and adds them back to the residue.
   // The residue ends at most 127, and exactly 127 counts one more.
   assign quo_c = dq_ff + DIV_W'(rem_ff == DIV_W'(DIVISOR));
   assign q_c   = neg_ff ? -$signed(quo_c) : $signed(quo_c);
   assign t_c   = $signed({12'b0, la_ff}) + q_c;

   assign exp_prod = mant_ff * EXP_TBL[cmd.exp_idx];
   assign exp_rnd  = exp_prod + (64'd1 << (LQ - 1));

   assign sh_c   = $signed({ip_ff[17], ip_ff}) - 19'sd30;
   assign sneg_c = 19'(-sh_c);
   assign s_c    = sneg_c[5:0];

   always_comb begin
      if (!sh_c[18]) begin
         if (sh_c > 19'sd31) begin
            p_c = 64'd1 << 62;
         end else begin
            p_c = {32'b0, mant_ff} << sh_c[4:0];
         end
      end else if (sneg_c >= 19'd63) begin
         p_c = '0;
      end else begin
         p_c = ({32'b0, mant_ff} + (64'd1 << (s_c - 6'd1))) >> s_c;
      end
   end

   assign val_log = sat32($signed({2'b0, p_ff}) - $signed({32'b0, ONE_Q})
                          - $signed({{33{off_ff[32]}}, off_ff}));
   assign val_lin = sat32($signed({{34{mn_ff[31]}}, mn_ff})
                          + $signed({{18{q_c[DIV_W-1]}}, q_c}));

   always_ff @(posedge clock) begin
      if (reset) begin
         mn_ff    <= '0;
         mx_ff    <= 32'(ONE_Q);
         log_ff   <= 1'b0;
         sel_ff   <= '0;
         armed_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RANGE_MIN: mn_ff  <= csr_wdata;
               CSR_RANGE_MAX: mx_ff  <= csr_wdata;
               CSR_LOG_MODE:  log_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.decode) begin
            if (op_ff == OP_LEARN) begin
               armed_ff <= 1'b1;
            end else if (is_cc && armed_ff) begin
               sel_ff   <= number_ff;
               armed_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= in_op;
         cmpl_ff   <= in_complete;
         status_ff <= in_status;
         number_ff <= in_number;
         value_ff  <= in_value;
         frame_ff  <= in_frame;
      end
      if (cmd.decode) begin
         res_fwd_ff <= (op_ff != OP_LEARN) && is_cc && match;
         res_err_ff <= (op_ff != OP_LEARN) && is_cc && match && log_ff && b_nonpos;
         res_vv_ff  <= 1'b0;
         res_val_ff <= '0;
         off_ff     <= off_c;
         x_ff       <= a_c;
         n_ff       <= 6'(NORM_W - 1);
      end
      if (cmd.norm) begin
         if (x_ff[NORM_W-1]) begin
            m_ff    <= x_ff[NORM_W-1:NORM_W-1-LQ];
            frac_ff <= '0;
         end else begin
            x_ff <= x_ff << 1;
            n_ff <= n_ff - 6'd1;
         end
      end
      if (cmd.sqr) begin
         if (sq_top[31]) begin
            m_ff    <= sq_top[31:1];
            frac_ff <= {frac_ff[LQ-2:0], 1'b1};
         end else begin
            m_ff    <= sq_top[30:0];
            frac_ff <= {frac_ff[LQ-2:0], 1'b0};
         end
      end
      if (cmd.load_b) begin
         la_ff <= {n_ff, frac_ff};
         x_ff  <= b_c;
         n_ff  <= 6'(NORM_W - 1);
      end
      if (cmd.mul) begin
         prod_ff <= prod_c;
      end
      if (cmd.div_load) begin
         neg_ff <= prod_ff[DIV_W-1];
         dq_ff  <= '0;
         rem_ff <= mag_c;
      end
      if (cmd.div_step) begin
         dq_ff  <= dq_ff + (rem_ff >> DIV_SHIFT);
         rem_ff <= (rem_ff >> DIV_SHIFT) + DIV_W'(rem_ff[DIV_SHIFT-1:0]);
      end
      if (cmd.exp_load) begin
         ip_ff   <= t_c[DIV_W-1:LQ];
         frac_ff <= t_c[LQ-1:0];
         mant_ff <= 32'd1 << LQ;
      end
      if (cmd.exp_step) begin
         if (frac_ff[LQ-1]) begin
            mant_ff <= exp_rnd[LQ+31:LQ];
         end
         frac_ff <= frac_ff << 1;
      end
      if (cmd.shift) begin
         p_ff <= p_c;
      end
      if (cmd.fin_log) begin
         res_vv_ff  <= 1'b1;
         res_val_ff <= val_log;
      end
      if (cmd.fin_lin) begin
         res_vv_ff  <= 1'b1;
         res_val_ff <= val_lin;
      end
      if (cmd.publish) begin
         o_fwd_ff   <= res_fwd_ff;
         o_vv_ff    <= res_vv_ff;
         o_err_ff   <= res_err_ff;
         o_val_ff   <= res_val_ff;
         o_frame_ff <= frame_ff;
      end
   end

   assign out_forwarded   = o_fwd_ff;
   assign out_value_valid = o_vv_ff;
   assign out_scaled      = o_val_ff;
   assign out_range_error = o_err_ff;
   assign out_frame       = o_frame_ff;

endmodule

@@ design/midi_cc_learn_and_scale_core.sv @@
// ----------------------------------------------------------------------------
// MIDI CC learn and scale core
// Control-change learn, match and linear or logarithmic range mapping.
// ----------------------------------------------------------------------------
// Usage: req_ch carries a MIDI event or a learn-arm command; each accepted
// transaction gives exactly one transaction on rsp_ch. csr_we/csr_index/
// csr_wdata write range_min (0), range_max (1) and log_mode (2) while idle.
// One request is in work at a time; req_ch.ready is high only when the
// sequencer is idle. Before a response is held in the output register,
// learn commands, non-CC events, mismatches and range errors need only
// decode; a linear mapping also runs the multiply and the 8-step divide by
// 127; a log mapping runs two normalize-and-square log2 passes (up to 34
// normalize and 30 squaring steps each), the divider and 30 exp2 steps.
// req_ch.ready is high again as soon as a result enters the output register.
// The output register decouples the sides: a new request is accepted while
// a response waits; if the receiver stalls, the next finished result waits
// in the core until the output register is taken. Reset clears the learn
// state, restores range 0..1.0 in linear mode and empties both channels.
// ----------------------------------------------------------------------------
module midi_cc_learn_and_scale_core (
   input  logic        clock,
   input  logic        reset,
   mccls_req_if.sink   req_ch,
   mccls_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import mccls_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   mccls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   mccls_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_op           (req_ch.op),
      .in_complete     (req_ch.is_complete_midi),
      .in_status       (req_ch.status_byte),
      .in_number       (req_ch.controller_number),
      .in_value        (req_ch.controller_value),
      .in_frame        (req_ch.frame_offset),
      .out_forwarded   (rsp_ch.forwarded),
      .out_value_valid (rsp_ch.value_valid),
      .out_scaled      (rsp_ch.mapped_value),
      .out_range_error (rsp_ch.range_error),
      .out_frame       (rsp_ch.out_frame_offset)
   );

endmodule
